[hw/rtl/hex_dump_row_formatter_top_defines.svh]
// Assertion macros for the hex-dump row formatter.
`ifndef HEX_DUMP_ROW_FORMATTER_TOP_DEFINES_SVH
`define HEX_DUMP_ROW_FORMATTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HDRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdrf: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define HDRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdrf: next-cycle check failed");

`endif

[hw/rtl/hdrf_pkg.sv]
`default_nettype none

package hdrf_pkg;

    // Row geometry
    localparam int ROW_BYTES   = 16;
    localparam int ROW_IDX_W   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int ROW_CNT_W   = $clog2(ROW_BYTES + 1);

    // Offset column
    localparam int OFS_W       = 32;
    localparam int NIB_W       = 4;
    localparam int OFS_DIGITS  = OFS_W / NIB_W;
    localparam int STEP_W      = $clog2(OFS_DIGITS);

    // Output packing
    localparam int GROUP_CHARS = 4;
    localparam int FILL_W      = $clog2(GROUP_CHARS);
    localparam int COUNT_W     = 3;

    typedef logic [6:0] t_char;

    // Character codes
    localparam t_char CH_SPACE = 7'h20;
    localparam t_char CH_BAR   = 7'h7c;
    localparam t_char CH_DOT   = 7'h2e;
    localparam t_char CH_CR    = 7'h0d;
    localparam t_char CH_LF    = 7'h0a;
    localparam t_char CH_ZERO  = 7'h30;
    localparam t_char CH_ALPHA = 7'h57;   // 'a' - 10
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7e;

    // One character per cycle from the sequencer to the packer, unless the packer stalls
    typedef struct packed {
        logic  vld;
        logic  last;
        t_char ch;
    } t_char_bus;

    // Lowercase hex digit
    function automatic t_char hex_char(input logic [NIB_W-1:0] nib);
        return (nib < 4'd10) ? (CH_ZERO + {3'b000, nib}) : (CH_ALPHA + {3'b000, nib});
    endfunction

    // Printable bytes as is, everything else as a dot
    function automatic t_char ascii_char(input logic [7:0] b);
        return (b >= PRINT_LO && b <= PRINT_HI) ? b[6:0] : CH_DOT;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hdrf_if.sv]
`default_nettype none

// Byte input channel
interface hdrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// Character group output channel
interface hdrf_out_if;
    import hdrf_pkg::*;

    logic               valid;
    logic               ready;
    t_char              char_a;
    t_char              char_b;
    t_char              char_c;
    t_char              char_d;
    logic [COUNT_W-1:0] char_count;
    logic               last_group;

    modport source (output valid, output char_a, output char_b, output char_c,
                    output char_d, output char_count, output last_group, input ready);
    modport sink   (input valid, input char_a, input char_b, input char_c,
                    input char_d, input char_count, input last_group, output ready);
endinterface

`default_nettype wire

[hw/rtl/hdrf_packer.sv]
`default_nettype none

module hdrf_packer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hdrf_pkg::t_char_bus i_char,
    output logic                   o_stall,
    hdrf_out_if.source             o_out
);
    import hdrf_pkg::*;

    t_char              r_grp [GROUP_CHARS];
    logic [FILL_W-1:0]  r_fill;
    logic               r_out_vld;
    t_char              r_out_chr [GROUP_CHARS];
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_last;

    t_char              w_grp [GROUP_CHARS];
    logic               w_close;
    logic               w_take;

    // A group closes on its fourth character or on the row's last one
    assign w_close = i_char.vld && ((r_fill == FILL_W'(GROUP_CHARS - 1)) || i_char.last);
    assign o_stall = w_close && r_out_vld && !o_out.ready;
    assign w_take  = i_char.vld && !o_stall;

    // Held characters, then the incoming one, unused slots zero
    always_comb begin
        for (int k = 0; k < GROUP_CHARS; k++) begin
            if (FILL_W'(k) < r_fill) begin
                w_grp[k] = r_grp[k];
            end else if (FILL_W'(k) == r_fill) begin
                w_grp[k] = i_char.ch;
            end else begin
                w_grp[k] = '0;
            end
        end
    end

    // Group assembly and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_take && w_close) begin
                r_out_chr  <= w_grp;
                r_out_cnt  <= COUNT_W'(r_fill) + COUNT_W'(1);
                r_out_last <= i_char.last;
                r_out_vld  <= 1'b1;
                r_fill     <= '0;
            end else begin
                if (r_out_vld && o_out.ready) begin
                    r_out_vld <= 1'b0;
                end
                if (w_take) begin
                    r_grp[r_fill] <= i_char.ch;
                    r_fill        <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.char_a     = r_out_chr[0];
    assign o_out.char_b     = r_out_chr[1];
    assign o_out.char_c     = r_out_chr[2];
    assign o_out.char_d     = r_out_chr[3];
    assign o_out.char_count = r_out_cnt;
    assign o_out.last_group = r_out_last;

endmodule

`default_nettype wire

[hw/rtl/hex_dump_row_formatter_top.sv]
// Hex-dump row formatter.
// Input channel i_in takes one byte per word with an end_of_buffer flag.
// Output channel o_out gives text in words of up to four characters
// (char_a first), char_count valid ones, last_group on the row's final word.
// Each row is 78 characters: 8-digit offset, 16 hex pairs (blank padded),
// " |", ASCII column, "|" CR LF, i.e. 20 words, the last holding 2 characters.
// A byte that neither fills the row nor ends the buffer gives no output.
// A closing byte starts a sequencer that produces one character per cycle
// while the packer does not stall it, through a shared character unit
// (offset shift register, row store read port, hex/ASCII conversion).
// The next byte is accepted only after the sequencer has produced the row's
// last character: i_in.ready is high only while the sequencer is idle.
// When the receiver holds o_out.ready low, the output register holds its word
// and the sequencer halts on the character that would complete the next word.
// Synchronous active-low reset clears the offset counter, the row position,
// the sequencer and the output valid; row store contents are not cleared.
`default_nettype none

module hex_dump_row_formatter_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hdrf_in_if.sink    i_in,
    hdrf_out_if.source o_out
);
    import hdrf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_OFS, S_SP, S_HEX, S_BAR, S_ASC, S_END
    } t_state;

    // Sub-steps inside a hex field and the fixed text runs
    localparam logic [STEP_W-1:0] STEP_HI  = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_LO  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_SEP = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_OFS_LAST = STEP_W'(OFS_DIGITS - 1);
    localparam logic [STEP_W-1:0] STEP_PAIR_LAST = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_END_LAST  = STEP_W'(2);

    t_state               r_state;
    logic [STEP_W-1:0]    r_step;
    logic [ROW_IDX_W-1:0] r_bidx;
    logic [ROW_IDX_W-1:0] r_pos;
    logic [ROW_CNT_W-1:0] r_cnt;
    logic [OFS_W-1:0]     r_offset;
    logic [OFS_W-1:0]     r_shift;
    logic [7:0]           r_store [ROW_BYTES];

    logic       w_accept;
    logic       w_closes;
    logic [7:0] w_byte;
    logic       w_have;
    logic       w_last_byte;
    logic       w_stall;
    logic       w_adv;
    t_char_bus  w_char;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_closes   = i_in.end_of_buffer || (r_pos == ROW_IDX_W'(ROW_BYTES - 1));

    // Row store read port, shared by the hex and ASCII columns
    assign w_byte      = r_store[r_bidx];
    assign w_have      = ROW_CNT_W'(r_bidx) < r_cnt;
    assign w_last_byte = (r_bidx == ROW_IDX_W'(ROW_BYTES - 1));

    // Character unit
    always_comb begin
        w_char.vld  = 1'b1;
        w_char.last = 1'b0;
        w_char.ch   = CH_SPACE;
        unique case (r_state)
            S_IDLE: begin
                w_char.vld = 1'b0;
            end
            S_OFS: begin
                w_char.ch = hex_char(r_shift[OFS_W-1 -: NIB_W]);
            end
            S_SP: begin
                w_char.ch = CH_SPACE;
            end
            S_HEX: begin
                if (w_have && r_step == STEP_HI) begin
                    w_char.ch = hex_char(w_byte[7:4]);
                end else if (w_have && r_step == STEP_LO) begin
                    w_char.ch = hex_char(w_byte[3:0]);
                end
            end
            S_BAR: begin
                w_char.ch = (r_step == STEP_PAIR_LAST) ? CH_BAR : CH_SPACE;
            end
            S_ASC: begin
                if (w_have) begin
                    w_char.ch = ascii_char(w_byte);
                end
            end
            S_END: begin
                if (r_step == STEP_HI) begin
                    w_char.ch = CH_BAR;
                end else if (r_step == STEP_LO) begin
                    w_char.ch = CH_CR;
                end else begin
                    w_char.ch   = CH_LF;
                    w_char.last = 1'b1;
                end
            end
            default: begin
                w_char.vld = 1'b0;
            end
        endcase
    end

    assign w_adv = w_char.vld && !w_stall;

    // Row store writes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store[r_pos] <= i_in.data_byte;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_bidx   <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_offset <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_offset <= r_offset + OFS_W'(1);
                        if (w_closes) begin
                            r_cnt   <= ROW_CNT_W'(r_pos) + ROW_CNT_W'(1);
                            r_shift <= r_offset - OFS_W'(r_pos);
                            r_pos   <= '0;
                            r_step  <= '0;
                            r_state <= S_OFS;
                        end else begin
                            r_pos <= r_pos + ROW_IDX_W'(1);
                        end
                    end
                end
                S_OFS: begin
                    if (w_adv) begin
                        r_shift <= r_shift << NIB_W;
                        if (r_step == STEP_OFS_LAST) begin
                            r_step  <= '0;
                            r_state <= S_SP;
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end
                end
                S_SP: begin
                    if (w_adv) begin
                        if (r_step == STEP_PAIR_LAST) begin
                            r_step  <= STEP_HI;
                            r_bidx  <= '0;
                            r_state <= S_HEX;
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end
                end
                S_HEX: begin
                    if (w_adv) begin
                        if (r_step == STEP_HI) begin
                            r_step <= STEP_LO;
                        end else if (r_step == STEP_LO && w_last_byte) begin
                            r_step  <= '0;
                            r_state <= S_BAR;
                        end else if (r_step == STEP_LO) begin
                            r_step <= STEP_SEP;
                        end else begin
                            r_step <= STEP_HI;
                            r_bidx <= r_bidx + ROW_IDX_W'(1);
                        end
                    end
                end
                S_BAR: begin
                    if (w_adv) begin
                        if (r_step == STEP_PAIR_LAST) begin
                            r_bidx  <= '0;
                            r_state <= S_ASC;
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end
                end
                S_ASC: begin
                    if (w_adv) begin
                        if (w_last_byte) begin
                            r_step  <= '0;
                            r_state <= S_END;
                        end else begin
                            r_bidx <= r_bidx + ROW_IDX_W'(1);
                        end
                    end
                end
                S_END: begin
                    if (w_adv) begin
                        if (r_step == STEP_END_LAST) begin
                            r_step  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Packing into words and output register
    hdrf_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (w_char),
        .o_stall (w_stall),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[hw/rtl/hdrf_checker.sv]
`default_nettype none
`include "hex_dump_row_formatter_top_defines.svh"

module hdrf_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire hdrf_pkg::t_char             i_char_c,
    input wire hdrf_pkg::t_char             i_char_d,
    input wire logic [hdrf_pkg::COUNT_W-1:0] i_char_count,
    input wire logic                        i_last_group
);
    import hdrf_pkg::*;

    logic w_count_ok;
    logic w_short;
    logic w_short_ok;
    logic w_two;
    logic w_pad_zero;

    assign w_count_ok = (i_char_count != '0) && (i_char_count <= COUNT_W'(GROUP_CHARS));
    assign w_short    = i_out_valid && (i_char_count != COUNT_W'(GROUP_CHARS));
    assign w_short_ok = i_last_group && (i_char_count == COUNT_W'(2));
    assign w_two      = i_out_valid && (i_char_count == COUNT_W'(2));
    assign w_pad_zero = (i_char_c == '0) && (i_char_d == '0);

    // Word size stays in range
    `HDRF_ASSERT_IMP(a_count_range, i_clk, i_rst_n, i_out_valid, w_count_ok)

    // Only the row's final word is short, and it carries "\r\n" alone
    `HDRF_ASSERT_IMP(a_short_is_last, i_clk, i_rst_n, w_short, w_short_ok)

    // Unused slots of a short word read zero
    `HDRF_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, w_two, w_pad_zero)

    // A stalled word stays offered
    `HDRF_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

endmodule

bind hex_dump_row_formatter_top hdrf_checker u_hdrf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_char_c     (o_out.char_c),
    .i_char_d     (o_out.char_d),
    .i_char_count (o_out.char_count),
    .i_last_group (o_out.last_group)
);

`default_nettype wire

[bench/hdrf_row_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the hex-dump row formatter, builds the text each
// closing byte should produce and compares every output word against it.
module hdrf_row_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hdrf_in_if        i_in_ch,
    hdrf_out_if       i_out_ch,
    output int        o_mismatch_count,
    output int        o_words_outstanding
);
    import hdrf_pkg::*;

    localparam int LINE_CHARS = 14 + 4 * ROW_BYTES;

    typedef struct packed {
        t_char              char_a;
        t_char              char_b;
        t_char              char_c;
        t_char              char_d;
        logic [COUNT_W-1:0] char_count;
        logic               last_group;
    } t_text_word;

    // Shadow of the block's row state
    logic [7:0]         row_bytes [ROW_BYTES];
    int unsigned        row_fill = 0;
    logic [OFS_W-1:0]   bytes_seen = '0;

    t_char              line_text [LINE_CHARS];
    t_text_word         pending_words [$];
    t_text_word         seen_word;
    t_text_word         want_word;
    int unsigned        words_checked = 0;

    // Lowercase hex glyph of one nibble
    function automatic t_char nibble_glyph(input logic [3:0] v);
        if (v < 4'd10)
            return 7'h30 + {3'b000, v};
        return 7'h61 + {3'b000, v} - 7'd10;
    endfunction

    // Printable range as is, anything else as a dot
    function automatic t_char column_glyph(input logic [7:0] b);
        if (b >= 8'h20 && b <= 8'h7e)
            return b[6:0];
        return CH_DOT;
    endfunction

    // Take one byte; on a full or closed row queue its 20 text words
    task automatic absorb_byte(input logic [7:0] b, input logic eob);
        int unsigned      held;
        logic [OFS_W-1:0] row_start;
        int               n;
        int               groups;
        int               fill;
        t_text_word       w;

        row_bytes[row_fill] = b;
        held       = row_fill + 1;
        bytes_seen = bytes_seen + 1'b1;
        if (!eob && held < ROW_BYTES) begin
            row_fill = held;
            return;
        end
        row_fill  = 0;
        row_start = bytes_seen - held[OFS_W-1:0];

        n = 0;
        for (int sh = OFS_W - NIB_W; sh >= 0; sh -= NIB_W) begin
            line_text[n] = nibble_glyph(row_start[sh +: NIB_W]);
            n++;
        end
        line_text[n] = CH_SPACE; line_text[n+1] = CH_SPACE; n += 2;
        for (int i = 0; i < ROW_BYTES; i++) begin
            if (i < held) begin
                line_text[n]   = nibble_glyph(row_bytes[i][7:4]);
                line_text[n+1] = nibble_glyph(row_bytes[i][3:0]);
            end else begin
                line_text[n]   = CH_SPACE;
                line_text[n+1] = CH_SPACE;
            end
            n += 2;
            if (i != ROW_BYTES - 1) begin
                line_text[n] = CH_SPACE;
                n++;
            end
        end
        line_text[n] = CH_SPACE; line_text[n+1] = CH_BAR; n += 2;
        for (int i = 0; i < ROW_BYTES; i++) begin
            line_text[n] = (i < held) ? column_glyph(row_bytes[i]) : CH_SPACE;
            n++;
        end
        line_text[n] = CH_BAR; line_text[n+1] = CH_CR; line_text[n+2] = CH_LF; n += 3;

        // Pack four to a word, unused slots zero
        groups = (n + 3) / 4;
        for (int g = 0; g < groups; g++) begin
            fill = (n - 4 * g > 4) ? 4 : n - 4 * g;
            w.char_a     = line_text[4*g];
            w.char_b     = (fill > 1) ? line_text[4*g+1] : '0;
            w.char_c     = (fill > 2) ? line_text[4*g+2] : '0;
            w.char_d     = (fill > 3) ? line_text[4*g+3] : '0;
            w.char_count = fill[COUNT_W-1:0];
            w.last_group = (g == groups - 1);
            pending_words = {pending_words, w};
        end
    endtask

    task automatic flag_field(input string field, input int want, input int got);
        o_mismatch_count++;
        if (o_mismatch_count <= 10)
            $display("%0t: word %0d %s mismatch: expected %0h, got %0h",
                     $time, words_checked, field, want, got);
    endtask

    // Sample both channels at the edge; input side first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_fill         = 0;
            bytes_seen       = '0;
            o_mismatch_count = 0;
            pending_words.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready)
                absorb_byte(i_in_ch.data_byte, i_in_ch.end_of_buffer);
            if (i_out_ch.valid && i_out_ch.ready) begin
                seen_word.char_a     = i_out_ch.char_a;
                seen_word.char_b     = i_out_ch.char_b;
                seen_word.char_c     = i_out_ch.char_c;
                seen_word.char_d     = i_out_ch.char_d;
                seen_word.char_count = i_out_ch.char_count;
                seen_word.last_group = i_out_ch.last_group;
                if (pending_words.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= 10)
                        $display("%0t: word %0d arrived with nothing expected: %0h",
                                 $time, words_checked, seen_word);
                end else begin
                    want_word = pending_words.pop_front();
                    if (seen_word.char_a !== want_word.char_a)
                        flag_field("char_a", want_word.char_a, seen_word.char_a);
                    if (seen_word.char_b !== want_word.char_b)
                        flag_field("char_b", want_word.char_b, seen_word.char_b);
                    if (seen_word.char_c !== want_word.char_c)
                        flag_field("char_c", want_word.char_c, seen_word.char_c);
                    if (seen_word.char_d !== want_word.char_d)
                        flag_field("char_d", want_word.char_d, seen_word.char_d);
                    if (seen_word.char_count !== want_word.char_count)
                        flag_field("char_count", want_word.char_count,
                                   seen_word.char_count);
                    if (seen_word.last_group !== want_word.last_group)
                        flag_field("last_group", want_word.last_group,
                                   seen_word.last_group);
                end
                words_checked++;
            end
        end
        o_words_outstanding <= pending_words.size();
    end

endmodule

[bench/tb_hex_dump_row_formatter_top.sv]
`timescale 1ns / 1ps

module tb_hex_dump_row_formatter_top;

    localparam int BYTE_TOTAL = 360;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   quiet = 1'b0;       // no idling on either side while set
    int   mismatches;
    int   outstanding;

    // Bytes around the printable range edges plus the row's own punctuation
    logic [7:0] corner_bytes [16] = '{8'h00, 8'h1f, 8'h20, 8'h41, 8'h7e, 8'h7f,
                                      8'h80, 8'hff, 8'h0a, 8'h0d, 8'h7c, 8'h2e,
                                      8'h5a, 8'h61, 8'h39, 8'h10};

    hdrf_in_if  byte_ch ();
    hdrf_out_if text_ch ();

    hex_dump_row_formatter_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (text_ch)
    );

    hdrf_row_checker row_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_ch             (byte_ch),
        .i_out_ch            (text_ch),
        .o_mismatch_count    (mismatches),
        .o_words_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stalls at random about 31 percent of the time, except while quiet is set
    always @(posedge i_clk) begin
        text_ch.ready <= quiet || ($urandom_range(99) >= 31);
    end

    // Offer one byte, with random gaps ahead of it, and wait for the handshake
    task automatic feed_byte(input logic [7:0] b, input logic eob);
        while (!quiet && $urandom_range(99) < 31) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.data_byte     <= b;
        byte_ch.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
    endtask

    // Hold off the sender until every queued word has come out
    task automatic drain_pause();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int  sent;
        int  run_len;
        bit  paused_mid;

        i_rst_n               <= 1'b0;
        byte_ch.valid         <= 1'b0;
        byte_ch.data_byte     <= 8'h00;
        byte_ch.end_of_buffer <= 1'b0;
        paused_mid = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-byte buffer, a row closed by filling, a short closed row
        feed_byte(8'h00, 1'b1);
        for (int k = 0; k < 16; k++)
            feed_byte(corner_bytes[k], 1'b0);
        feed_byte(8'hff, 1'b0);
        feed_byte(8'h41, 1'b0);
        feed_byte(8'h7f, 1'b1);
        sent = 20;
        drain_pause();

        // Random buffers, mostly short, some spanning several rows
        while (sent < BYTE_TOTAL) begin
            run_len = ($urandom_range(99) < 20) ? $urandom_range(16, 48)
                                                : $urandom_range(1, 20);
            if (run_len > BYTE_TOTAL - sent)
                run_len = BYTE_TOTAL - sent;
            quiet = (sent >= 150 && sent < 230);
            for (int k = 0; k < run_len; k++)
                feed_byte(8'($urandom_range(0, 255)), k == run_len - 1);
            sent += run_len;
            if (sent >= 260 && !paused_mid) begin
                paused_mid = 1'b1;
                drain_pause();
            end
        end
        quiet = 1'b0;

        // Let the last row drain, then a short settle
        drain_pause();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("hex_dump_row_formatter_top verification clean");
        else
            $display("hex_dump_row_formatter_top verification failed");
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("hex_dump_row_formatter_top verification failed");
        $finish;
    end

endmodule
